/* rtl/tgdw_pkg.sv */
// Package for the torus grid walk unit: defaults, register indexes, microcode and its table.
package tgdw_pkg;

  // Default grid shape
  localparam int unsigned DEF_GRID_WIDTH  = 4;
  localparam int unsigned DEF_GRID_HEIGHT = 8;

  // Field widths fixed by the interface
  localparam int unsigned KEY_W   = 32;
  localparam int unsigned IDX_W   = 5;
  localparam int unsigned LEVEL_W = 8;
  localparam int unsigned CFG_A_W = 3;
  localparam int unsigned CFG_D_W = 8;
  localparam int unsigned PC_W    = 4;

  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 8'hFF;
  localparam logic [2:0]         LAST_ROUND = 3'd7;

  // Configuration register indexes
  localparam logic [CFG_A_W-1:0] REG_WALK_MODE     = 3'd0;
  localparam logic [CFG_A_W-1:0] REG_GATE_MODE     = 3'd1;
  localparam logic [CFG_A_W-1:0] REG_CLAMP_ENABLE  = 3'd2;
  localparam logic [CFG_A_W-1:0] REG_ROTATE_AMOUNT = 3'd3;
  localparam logic [CFG_A_W-1:0] REG_START_CELL    = 3'd4;
  localparam logic [CFG_A_W-1:0] REG_LEVEL_SCALE   = 3'd5;

  // Step directions
  localparam logic [1:0] DIR_N = 2'd0;
  localparam logic [1:0] DIR_E = 2'd1;
  localparam logic [1:0] DIR_S = 2'd2;
  localparam logic [1:0] DIR_W = 2'd3;

  // Micro-operations
  typedef enum logic [2:0] {
    OP_IDLE,    // wait for a word, latch it
    OP_CLEAR,   // zero one cell per cycle
    OP_LOAD,    // load the step count for a direction
    OP_STEP,    // one step per cycle until the count runs out
    OP_RNDEND,  // next round in bit mode
    OP_EMRD,    // read a cell once the output register is free
    OP_EMLD,    // load the output register
    OP_END      // back to idle
  } op_e;

  // One control word: operation, direction, jump target
  typedef struct packed {
    op_e             op;
    logic [1:0]      dir;
    logic [PC_W-1:0] tgt;
  } ucode_t;

  // Program table
  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t uw;
    uw = '{op: OP_END, dir: DIR_N, tgt: 4'd0};
    case (pc)
      4'd0:  uw = '{op: OP_IDLE,   dir: DIR_N, tgt: 4'd1};
      4'd1:  uw = '{op: OP_CLEAR,  dir: DIR_N, tgt: 4'd2};
      4'd2:  uw = '{op: OP_LOAD,   dir: DIR_N, tgt: 4'd3};
      4'd3:  uw = '{op: OP_STEP,   dir: DIR_N, tgt: 4'd4};
      4'd4:  uw = '{op: OP_LOAD,   dir: DIR_E, tgt: 4'd5};
      4'd5:  uw = '{op: OP_STEP,   dir: DIR_E, tgt: 4'd6};
      4'd6:  uw = '{op: OP_LOAD,   dir: DIR_S, tgt: 4'd7};
      4'd7:  uw = '{op: OP_STEP,   dir: DIR_S, tgt: 4'd8};
      4'd8:  uw = '{op: OP_LOAD,   dir: DIR_W, tgt: 4'd9};
      4'd9:  uw = '{op: OP_STEP,   dir: DIR_W, tgt: 4'd10};
      4'd10: uw = '{op: OP_RNDEND, dir: DIR_N, tgt: 4'd2};
      4'd11: uw = '{op: OP_EMRD,   dir: DIR_N, tgt: 4'd12};
      4'd12: uw = '{op: OP_EMLD,   dir: DIR_N, tgt: 4'd11};
      4'd13: uw = '{op: OP_END,    dir: DIR_N, tgt: 4'd0};
      default: uw = '{op: OP_END,  dir: DIR_N, tgt: 4'd0};
    endcase
    return uw;
  endfunction

endpackage

/* rtl/tgdw_ram.sv */
// Generic single write port, single read port RAM with registered read data.
module tgdw_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* rtl/torus_grid_direction_walk_unit.sv */
// Top level of the torus grid walk unit: microcoded sequencer, cell RAM and output register.
//
// A 32-bit key word comes in on in_valid_i/in_ready_o; it is taken only while
// the sequencer sits idle. The word is rotated, its four bytes steer a walk on
// a GRID_WIDTH x GRID_HEIGHT torus, and one word per cell leaves on
// out_valid_o/out_ready_i, in cell order, with last_o on the final cell.
// Registers are written on cfg_valid_i/cfg_ready_o (always ready) by index.
// Per key word, with N cells: it is accepted, the N cells of the RAM are cleared,
// then in count mode the walk takes one cycle per step, the RAM read-modify-write
// being overlapped with the next step, and in bit mode it runs 8 rounds with one
// step per set bit; then each cell is read and loaded into the output register,
// and the sequencer returns to idle. Each output word takes a RAM read and then
// an output-register load, since the RAM read is registered.
// A stalled receiver holds the current output word and the sequencer waits
// on it; the final word of a run may still wait while the next key word is
// taken. Reset puts the sequencer idle, clears the output valid and sets the
// registers to their defaults; the cell RAM is cleared per word, not at reset.
module torus_grid_direction_walk_unit
  import tgdw_pkg::*;
#(
  parameter int unsigned GRID_WIDTH  = DEF_GRID_WIDTH,
  parameter int unsigned GRID_HEIGHT = DEF_GRID_HEIGHT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [KEY_W-1:0]   key_word_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [IDX_W-1:0]   cell_index_o,
  output logic [LEVEL_W-1:0] level_o,
  output logic               last_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CFG_A_W-1:0] cfg_index_i,
  input  logic [CFG_D_W-1:0] cfg_data_i
);

  localparam int unsigned CELLS = GRID_WIDTH * GRID_HEIGHT;
  localparam int unsigned AW    = $clog2(CELLS);
  localparam int unsigned XW    = $clog2(GRID_WIDTH);
  localparam int unsigned YW    = $clog2(GRID_HEIGHT);
  localparam int unsigned OW    = 9;

  localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
  localparam logic [XW-1:0] X_MAX     = XW'(GRID_WIDTH - 1);
  localparam logic [YW-1:0] Y_MAX     = YW'(GRID_HEIGHT - 1);
  localparam logic [OW-1:0] ORG_MAX   = OW'(CELLS - 1);

  // Configuration registers
  logic             walk_mode_q, gate_mode_q, clamp_enable_q;
  logic [5:0]       rotate_amount_q;
  logic [4:0]       start_cell_q;
  logic [7:0]       level_scale_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      walk_mode_q     <= 1'b1;
      gate_mode_q     <= 1'b1;
      clamp_enable_q  <= 1'b0;
      rotate_amount_q <= 6'd0;
      start_cell_q    <= 5'd18;
      level_scale_q   <= 8'd1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_WALK_MODE:     walk_mode_q     <= cfg_data_i[0];
        REG_GATE_MODE:     gate_mode_q     <= cfg_data_i[0];
        REG_CLAMP_ENABLE:  clamp_enable_q  <= cfg_data_i[0];
        REG_ROTATE_AMOUNT: rotate_amount_q <= cfg_data_i[5:0];
        REG_START_CELL:    start_cell_q    <= cfg_data_i[4:0];
        REG_LEVEL_SCALE:   level_scale_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sequencer and datapath registers
  logic [PC_W-1:0]    pc_q, pc_d;
  logic [KEY_W-1:0]   word_q, word_d;
  logic [XW-1:0]      x_q, x_d;
  logic [YW-1:0]      y_q, y_d;
  logic [7:0]         rem_q, rem_d;
  logic [2:0]         round_q, round_d;
  logic [AW-1:0]      cnt_q, cnt_d;
  logic               pend_q, pend_d;
  logic [AW-1:0]      pend_addr_q, pend_addr_d;
  logic               out_valid_q, out_valid_d;
  logic [IDX_W-1:0]   out_idx_q, out_idx_d;
  logic [LEVEL_W-1:0] out_level_q, out_level_d;
  logic               out_last_q, out_last_d;

  ucode_t uw;
  assign uw = ucode_rom(pc_q);

  // RAM port signals
  logic               ram_we;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic [7:0]         ram_wdata, ram_rdata;

  tgdw_ram #(
    .WIDTH (8),
    .DEPTH (CELLS)
  ) u_cells (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Rotated key word and start position
  logic [2*KEY_W-1:0] rot_wide;
  logic [KEY_W-1:0]   rot_word;
  logic [OW-1:0]      start_ext, origin;
  assign rot_wide  = {key_word_i, key_word_i} << rotate_amount_q[4:0];
  assign rot_word  = rot_wide[2*KEY_W-1:KEY_W];
  assign start_ext = {{(OW-5){1'b0}}, start_cell_q};
  assign origin    = (start_ext > ORG_MAX) ? ORG_MAX : start_ext;

  // Byte for the current direction, and the step count it gives
  logic [7:0] dir_byte, load_cnt;
  always_comb begin
    case (uw.dir)
      DIR_N:   dir_byte = word_q[31:24];
      DIR_E:   dir_byte = word_q[23:16];
      DIR_S:   dir_byte = word_q[15:8];
      default: dir_byte = word_q[7:0];
    endcase
    load_cnt = walk_mode_q ? dir_byte : {7'd0, dir_byte[round_q]};
  end

  // Next position on the torus
  logic [XW-1:0] nx;
  logic [YW-1:0] ny;
  logic [AW-1:0] naddr;
  always_comb begin
    nx = x_q;
    ny = y_q;
    case (uw.dir)
      DIR_N:   ny = (y_q == '0) ? Y_MAX : y_q - 1'b1;
      DIR_E:   nx = (x_q == X_MAX) ? '0 : x_q + 1'b1;
      DIR_S:   ny = (y_q == Y_MAX) ? '0 : y_q + 1'b1;
      default: nx = (x_q == '0) ? X_MAX : x_q - 1'b1;
    endcase
    naddr = AW'(ny * GRID_WIDTH) + AW'(nx);
  end

  // Output level of the cell just read
  logic [15:0]        prod;
  logic [LEVEL_W-1:0] cell_level;
  logic [31:0]        cnt_ext;
  always_comb begin
    prod = ram_rdata * level_scale_q;
    if (gate_mode_q) begin
      cell_level = (ram_rdata != 8'd0) ? LEVEL_MAX : 8'd0;
    end else if (clamp_enable_q && (prod > 16'(LEVEL_MAX))) begin
      cell_level = LEVEL_MAX;
    end else begin
      cell_level = prod[7:0];
    end
    cnt_ext = 32'(cnt_q);
  end

  logic out_free;
  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (uw.op == OP_IDLE);

  // Sequencer step
  always_comb begin
    pc_d        = pc_q;
    word_d      = word_q;
    x_d         = x_q;
    y_d         = y_q;
    rem_d       = rem_q;
    round_d     = round_q;
    cnt_d       = cnt_q;
    pend_d      = 1'b0;
    pend_addr_d = pend_addr_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_idx_d   = out_idx_q;
    out_level_d = out_level_q;
    out_last_d  = out_last_q;
    ram_raddr   = cnt_q;

    // pending read-modify-write lands in the cycle after its read
    ram_we    = pend_q;
    ram_waddr = pend_addr_q;
    ram_wdata = gate_mode_q ? (ram_rdata ^ 8'd1) : (ram_rdata + 8'd1);

    case (uw.op)
      OP_IDLE: begin
        if (in_valid_i) begin
          word_d  = rot_word;
          x_d     = '0;
          y_d     = '0;
          round_d = '0;
          cnt_d   = '0;
          pc_d    = uw.tgt;
        end
      end
      OP_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_q;
        ram_wdata = 8'd0;
        // scan position follows the clear pass up to the start cell
        if (OW'(cnt_q) < origin) begin
          if (x_q == X_MAX) begin
            x_d = '0;
            y_d = y_q + 1'b1;
          end else begin
            x_d = x_q + 1'b1;
          end
        end
        if (cnt_q == LAST_CELL) begin
          cnt_d = '0;
          pc_d  = uw.tgt;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      OP_LOAD: begin
        rem_d = load_cnt;
        pc_d  = uw.tgt;
      end
      OP_STEP: begin
        if (rem_q == 8'd0) begin
          pc_d = uw.tgt;
        end else begin
          x_d         = nx;
          y_d         = ny;
          ram_raddr   = naddr;
          pend_d      = 1'b1;
          pend_addr_d = naddr;
          rem_d       = rem_q - 1'b1;
        end
      end
      OP_RNDEND: begin
        if (!walk_mode_q && (round_q != LAST_ROUND)) begin
          round_d = round_q + 1'b1;
          pc_d    = uw.tgt;
        end else begin
          pc_d = pc_q + 1'b1;
        end
      end
      OP_EMRD: begin
        if (out_free) begin
          pc_d = uw.tgt;
        end
      end
      OP_EMLD: begin
        out_valid_d = 1'b1;
        out_idx_d   = cnt_ext[IDX_W-1:0];
        out_level_d = cell_level;
        out_last_d  = (cnt_q == LAST_CELL);
        if (cnt_q == LAST_CELL) begin
          pc_d = pc_q + 1'b1;
        end else begin
          cnt_d = cnt_q + 1'b1;
          pc_d  = uw.tgt;
        end
      end
      OP_END: begin
        pc_d = uw.tgt;
      end
      default: begin
        pc_d = '0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pc_q        <= pc_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    word_q      <= word_d;
    x_q         <= x_d;
    y_q         <= y_d;
    rem_q       <= rem_d;
    round_q     <= round_d;
    cnt_q       <= cnt_d;
    pend_addr_q <= pend_addr_d;
    out_idx_q   <= out_idx_d;
    out_level_q <= out_level_d;
    out_last_q  <= out_last_d;
  end

  assign out_valid_o  = out_valid_q;
  assign cell_index_o = out_idx_q;
  assign level_o      = out_level_q;
  assign last_o       = out_last_q;

endmodule

/* test/torus_grid_direction_walk_unit_tb.sv */
// Self-checking testbench for the torus grid walk unit: directed and random key words.
module torus_grid_direction_walk_unit_tb
  import tgdw_pkg::*;
();

  localparam int GRID_W       = DEF_GRID_WIDTH;
  localparam int GRID_H       = DEF_GRID_HEIGHT;
  localparam int CELLS        = GRID_W * GRID_H;
  localparam int QUIET_LIMIT  = 12000;
  localparam int HOLD_CYCLES  = 3000;
  localparam int CHUNK_WORDS  = 15;

  // One expected output word
  typedef struct {
    logic [IDX_W-1:0]   cell_index;
    logic [LEVEL_W-1:0] level;
    logic               last;
  } cell_word_t;

  // Mirrors the register file and the walk; holds the cell words still to come
  class cell_level_board;
    logic               count_walk;
    logic               gate_cells;
    logic               clamp_level;
    logic [5:0]         rot_amt;
    logic [4:0]         origin_cell;
    logic [7:0]         scale;
    logic [7:0]         grid [CELLS];
    int                 x;
    int                 y;
    cell_word_t         pending_cells [$];
    int                 mismatch_count;

    function new();
      count_walk     = 1'b1;
      gate_cells     = 1'b1;
      clamp_level    = 1'b0;
      rot_amt        = 6'd0;
      origin_cell    = 5'd18;
      scale          = 8'd1;
      mismatch_count = 0;
    endfunction

    function void write_reg(logic [CFG_A_W-1:0] idx, logic [CFG_D_W-1:0] data);
      case (idx)
        REG_WALK_MODE:     count_walk  = data[0];
        REG_GATE_MODE:     gate_cells  = data[0];
        REG_CLAMP_ENABLE:  clamp_level = data[0];
        REG_ROTATE_AMOUNT: rot_amt     = data[5:0];
        REG_START_CELL:    origin_cell = data[4:0];
        REG_LEVEL_SCALE:   scale       = data;
        default: ;
      endcase
    endfunction

    // One step on the torus, then mark the landing cell
    function void take_step(logic [1:0] dir);
      int idx;
      case (dir)
        DIR_N: y = (y == 0) ? GRID_H - 1 : y - 1;
        DIR_E: x = (x + 1 < GRID_W) ? x + 1 : 0;
        DIR_S: y = (y + 1 < GRID_H) ? y + 1 : 0;
        default: x = (x == 0) ? GRID_W - 1 : x - 1;
      endcase
      idx = x + GRID_W * y;
      if (gate_cells) grid[idx] = grid[idx] ^ 8'd1;
      else grid[idx] = grid[idx] + 8'd1;
    endfunction

    // Walk for one accepted key word and queue its cell words
    function void note_key_word(logic [KEY_W-1:0] key);
      logic [63:0] twice;
      logic [31:0] word;
      logic [7:0]  steps [4];
      logic [15:0] prod;
      int          origin;
      cell_word_t  cw;
      twice = {key, key} << rot_amt[4:0];
      word  = twice[63:32];
      for (int i = 0; i < CELLS; i++) grid[i] = 8'd0;
      origin = (origin_cell > CELLS - 1) ? CELLS - 1 : origin_cell;
      x = origin % GRID_W;
      y = origin / GRID_W;
      steps[0] = word[31:24];
      steps[1] = word[23:16];
      steps[2] = word[15:8];
      steps[3] = word[7:0];
      if (count_walk) begin
        for (int d = 0; d < 4; d++)
          for (int k = 0; k < steps[d]; k++) take_step(2'(d));
      end else begin
        for (int r = 0; r < 8; r++)
          for (int d = 0; d < 4; d++)
            if (steps[d][r]) take_step(2'(d));
      end
      for (int i = 0; i < CELLS; i++) begin
        cw.cell_index = IDX_W'(i);
        if (gate_cells) begin
          cw.level = (grid[i] != 0) ? LEVEL_MAX : 8'd0;
        end else begin
          prod = grid[i] * scale;
          cw.level = (clamp_level && prod > 16'd255) ? LEVEL_MAX : prod[7:0];
        end
        cw.last = (i == CELLS - 1);
        pending_cells.push_back(cw);
      end
    endfunction

    function void check_cell_word(logic [IDX_W-1:0] idx, logic [LEVEL_W-1:0] level,
                                  logic last);
      cell_word_t want;
      if (pending_cells.size() == 0) begin
        $display("%0t: unexpected cell word, expected none, got index %0d level %0d last %0d",
                 $time, idx, level, last);
        mismatch_count++;
        return;
      end
      want = pending_cells.pop_front();
      if (want.cell_index !== idx) begin
        $display("%0t: cell_index mismatch, expected %0d, got %0d", $time, want.cell_index, idx);
        mismatch_count++;
      end
      if (want.level !== level) begin
        $display("%0t: level mismatch at cell %0d, expected %0d, got %0d",
                 $time, want.cell_index, want.level, level);
        mismatch_count++;
      end
      if (want.last !== last) begin
        $display("%0t: last mismatch at cell %0d, expected %0d, got %0d",
                 $time, want.cell_index, want.last, last);
        mismatch_count++;
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni      = 1'b0;
  logic               in_valid    = 1'b0;
  logic               in_ready_o;
  logic [KEY_W-1:0]   key_word    = '0;
  logic               out_valid_o;
  logic               out_ready   = 1'b0;
  logic [IDX_W-1:0]   cell_index_o;
  logic [LEVEL_W-1:0] level_o;
  logic               last_o;
  logic               cfg_valid   = 1'b0;
  logic               cfg_ready_o;
  logic [CFG_A_W-1:0] cfg_index   = '0;
  logic [CFG_D_W-1:0] cfg_data    = '0;

  cell_level_board board = new();
  int sender_idle_pct = 0;
  int recv_idle_pct   = 0;
  int hold_req        = 0;
  int hold_seen       = 0;
  int hold_left       = 0;
  int quiet_cycles    = 0;

  torus_grid_direction_walk_unit uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready_o),
    .key_word_i   (key_word),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready),
    .cell_index_o (cell_index_o),
    .level_o      (level_o),
    .last_o       (last_o),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Receiver ready: random stalls, or a long hold-off when one is requested
  always @(posedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Output words checked as they are taken
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready) board.check_cell_word(cell_index_o, level_o, last_o);
  end

  // Watchdog on cycles with no word moving on any channel
  always @(posedge clk_i) begin
    if ((in_valid && in_ready_o) || (out_valid_o && out_ready) || (cfg_valid && cfg_ready_o))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("torus_grid_direction_walk_unit_tb: FAIL");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_A_W-1:0] idx, logic [CFG_D_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.write_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_all(logic walk, logic gate, logic clamp, logic [5:0] rot,
                         logic [4:0] start, logic [7:0] scale);
    write_reg(REG_WALK_MODE, {7'd0, walk});
    write_reg(REG_GATE_MODE, {7'd0, gate});
    write_reg(REG_CLAMP_ENABLE, {7'd0, clamp});
    write_reg(REG_ROTATE_AMOUNT, {{2{rot[5]}}, rot});
    write_reg(REG_START_CELL, {3'd0, start});
    write_reg(REG_LEVEL_SCALE, scale);
  endtask

  // Offer one key word after a random gap; returns at the accepting edge
  task automatic send_word(logic [KEY_W-1:0] key);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    key_word <= key;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_key_word(key);
  endtask

  // Stop offering and wait for every cell word still due
  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending_cells.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  function automatic logic [KEY_W-1:0] random_key();
    logic [KEY_W-1:0] k;
    case ($urandom_range(0, 4))
      0: k = {4'd0, 4'($urandom), 4'd0, 4'($urandom), 4'd0, 4'($urandom), 4'd0, 4'($urandom)};
      1: k = 32'($urandom_range(0, 255)) << (8 * $urandom_range(0, 3));
      2: k = ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : (32'd1 << $urandom_range(0, 31));
      default: k = $urandom;
    endcase
    return k;
  endfunction

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Reset defaults: count walk, gates, start cell 18
    send_word(32'h0000_0000);
    send_word(32'hFFFF_FFFF);
    send_word(32'h0102_0304);
    send_word(32'h8000_0000);
    drain();
    // Visit counts, unit scale
    set_all(1'b1, 1'b0, 1'b0, 6'd0, 5'd18, 8'd1);
    send_word(32'hFFFF_FFFF);
    send_word(32'h00FF_00FF);
    send_word(32'h1234_5678);
    drain();
    // Full scale, saturated and wrapped
    set_all(1'b1, 1'b0, 1'b1, 6'd0, 5'd5, 8'd255);
    send_word(32'hFFFF_FFFF);
    send_word(32'h0100_0000);
    drain();
    set_all(1'b1, 1'b0, 1'b0, 6'd0, 5'd5, 8'd255);
    send_word(32'h0303_0303);
    drain();
    // Zero scale gives level zero
    set_all(1'b1, 1'b0, 1'b1, 6'd0, 5'd31, 8'd0);
    send_word(32'hFFFF_FFFF);
    drain();
    // Bit rounds, gates then counts
    set_all(1'b0, 1'b1, 1'b0, 6'd0, 5'd0, 8'd1);
    send_word(32'hFFFF_FFFF);
    send_word(32'hAAAA_5555);
    send_word(32'h8040_2010);
    drain();
    set_all(1'b0, 1'b0, 1'b1, 6'd31, 5'd0, 8'd37);
    send_word(32'hFF00_FF00);
    send_word(32'h0000_FF01);
    drain();
    // Rotation extremes: -31, and -32 which is a full turn
    set_all(1'b1, 1'b1, 1'b0, 6'h21, 5'd31, 8'd1);
    send_word(32'h0000_00FF);
    drain();
    set_all(1'b1, 1'b0, 1'b0, 6'h20, 5'd9, 8'd3);
    send_word(32'h0F0E_0D0C);
    drain();

    // Random part in three idling phases, new settings per chunk
    for (int ph = 0; ph < 3; ph++) begin
      sender_idle_pct = (ph == 0) ? 6 : (ph == 1) ? 66 : 0;
      recv_idle_pct   = (ph == 0) ? 66 : (ph == 1) ? 6 : 0;
      for (int ch = 0; ch < 6; ch++) begin
        if (ch == 0)
          set_all(1'b0, 1'b0, 1'b0, 6'h21, 5'd0, 8'd1);
        else if (ch == 1)
          set_all(1'b1, 1'b0, 1'b1, 6'd31, 5'd31, 8'd255);
        else
          set_all(1'($urandom), 1'($urandom), 1'($urandom), 6'($urandom), 5'($urandom),
                  8'($urandom));
        // long receiver hold-off so that the unit backs up its input
        if (ph == 2 && ch == 0) hold_req++;
        repeat (CHUNK_WORDS) send_word(random_key());
        drain();
      end
    end

    repeat (40) @(posedge clk_i);
    if (board.mismatch_count == 0 && board.pending_cells.size() == 0) begin
      $display("torus_grid_direction_walk_unit_tb: PASS");
    end else begin
      $display("torus_grid_direction_walk_unit_tb: FAIL");
    end
    $finish;
  end

endmodule

/* torus_grid_direction_walk_unit.f */
rtl/tgdw_pkg.sv
rtl/tgdw_ram.sv
rtl/torus_grid_direction_walk_unit.sv
test/torus_grid_direction_walk_unit_tb.sv
